FILE: src/ibe_pkg.sv
package ibe_pkg;

  // Command codes carried by a request.
  typedef enum logic [2:0] {
    CMD_NONE     = 3'd0,
    CMD_START    = 3'd1,
    CMD_STOP     = 3'd2,
    CMD_WRITE    = 3'd3,
    CMD_READ     = 3'd4,
    CMD_ACK      = 3'd5,
    CMD_NACK     = 3'd6,
    CMD_WAIT_ACK = 3'd7
  } cmd_t;

  // Fields of one input request.
  typedef struct packed {
    logic [2:0] command;
    logic [7:0] write_data;
    logic       sda_in;
  } in_item_t;

  // Fields of one result.
  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       nack_seen;
  } out_item_t;

  localparam logic [15:0] PHASE_TICKS_RST = 16'd10;
  localparam logic [4:0]  WRITE_LAST_STEP = 5'd24;
  localparam logic [4:0]  READ_LAST_STEP  = 5'd16;

  // Number of held steps in each command's sequence.
  function automatic logic [4:0] step_count(input cmd_t cmd);
    logic [4:0] cnt;
    case (cmd) inside
      CMD_START:                        cnt = 5'd2;
      CMD_WRITE:                        cnt = 5'd25;
      CMD_READ:                         cnt = 5'd17;
      CMD_STOP, CMD_ACK, CMD_NACK,
      CMD_WAIT_ACK:                     cnt = 5'd4;
      default:                          cnt = 5'd0;
    endcase
    return cnt;
  endfunction

  // Remainder by three of a step index, using a reciprocal multiply.
  function automatic logic [1:0] mod3(input logic [4:0] v);
    logic [8:0] prod;
    logic [3:0] q;
    logic [5:0] rem;
    prod = {4'd0, v} * 9'd11;
    q    = prod[8:5];
    rem  = {1'b0, v} - {1'b0, q, 1'b0} - {2'b00, q};
    return rem[1:0];
  endfunction

endpackage

FILE: src/i2c_master_bit_engine_top.sv
// A result is registered in the cycle after its request is accepted.
// Throughput: one request per cycle unless out_ready stalls a held result;
// the output register takes a new request as the previous result leaves.
// Reset (synchronous, rst_n low): engine idle, SCL and SDA released,
// read data and nack flag cleared, phase_ticks set to 10, no result pending.
module i2c_master_bit_engine_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ibe_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ibe_pkg::out_item_t out_data,
  input  logic               cfg_wr_en,
  input  logic [15:0]        cfg_wr_data
);

  logic               accept;
  logic [15:0]        phase_ticks_r;
  ibe_pkg::out_item_t result_nxt;

  // Phase length register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_ticks_r <= ibe_pkg::PHASE_TICKS_RST;
    end else if (cfg_wr_en) begin
      phase_ticks_r <= cfg_wr_data;
    end
  end

  ibe_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .item        (in_data),
    .phase_ticks (phase_ticks_r),
    .result_nxt  (result_nxt)
  );

  ibe_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .result_nxt (result_nxt),
    .accept     (accept),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

FILE: src/ibe_core.sv
module ibe_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  ibe_pkg::in_item_t  item,
  input  logic [15:0]        phase_ticks,
  output ibe_pkg::out_item_t result_nxt
);

  ibe_pkg::cmd_t active_r, active_nxt;
  logic [4:0]    step_r, step_nxt;
  logic [15:0]   hold_r, hold_nxt;
  logic [7:0]    shift_r, shift_nxt;
  logic          scl_r, scl_nxt;
  logic          sda_r, sda_nxt;
  logic [7:0]    recv_r, recv_nxt;
  logic          nack_r, nack_nxt;
  logic          done;

  logic          apply_en;
  ibe_pkg::cmd_t a_cmd;
  logic [4:0]    a_step;
  logic [7:0]    a_shift;
  logic [4:0]    step_inc;
  logic [15:0]   ph;
  ibe_pkg::cmd_t in_cmd;

  assign in_cmd   = ibe_pkg::cmd_t'(item.command);
  assign step_inc = step_r + 5'd1;
  assign ph       = (phase_ticks == 16'd0) ? 16'd1 : phase_ticks;

  // Sequencer: start a command when idle, count the hold, then advance.
  always_comb begin
    active_nxt = active_r;
    step_nxt   = step_r;
    hold_nxt   = hold_r;
    done       = 1'b0;
    apply_en   = 1'b0;
    a_cmd      = active_r;
    a_step     = step_inc;
    a_shift    = shift_r;
    if (active_r == ibe_pkg::CMD_NONE) begin
      if (in_cmd != ibe_pkg::CMD_NONE) begin
        active_nxt = in_cmd;
        step_nxt   = 5'd0;
        hold_nxt   = ph;
        apply_en   = 1'b1;
        a_cmd      = in_cmd;
        a_step     = 5'd0;
        a_shift    = (in_cmd == ibe_pkg::CMD_WRITE) ? item.write_data : 8'd0;
      end
    end else if (hold_r > 16'd1) begin
      hold_nxt = hold_r - 16'd1;
    end else if (step_inc < ibe_pkg::step_count(active_r)) begin
      step_nxt = step_inc;
      hold_nxt = ph;
      apply_en = 1'b1;
    end else begin
      active_nxt = ibe_pkg::CMD_NONE;
      step_nxt   = 5'd0;
      hold_nxt   = 16'd0;
      done       = 1'b1;
    end
  end

  // Line levels and data registers set by the step that begins this tick.
  always_comb begin
    shift_nxt = shift_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    recv_nxt  = recv_r;
    nack_nxt  = nack_r;
    if (apply_en) begin
      shift_nxt = a_shift;
      case (a_cmd) inside
        ibe_pkg::CMD_START: begin
          if (a_step == 5'd0) begin
            sda_nxt = 1'b1;
            scl_nxt = 1'b1;
          end else begin
            sda_nxt = 1'b0;
          end
        end
        ibe_pkg::CMD_STOP: begin
          case (a_step[1:0])
            2'd0:    scl_nxt = 1'b0;
            2'd1:    sda_nxt = 1'b0;
            2'd2:    scl_nxt = 1'b1;
            default: sda_nxt = 1'b1;
          endcase
        end
        ibe_pkg::CMD_ACK, ibe_pkg::CMD_NACK, ibe_pkg::CMD_WAIT_ACK: begin
          case (a_step[1:0])
            2'd0:    scl_nxt = 1'b0;
            2'd1:    sda_nxt = (a_cmd != ibe_pkg::CMD_ACK);
            2'd2:    scl_nxt = 1'b1;
            default: begin
              if (a_cmd == ibe_pkg::CMD_WAIT_ACK) begin
                nack_nxt = item.sda_in;
              end
              scl_nxt = 1'b0;
            end
          endcase
        end
        ibe_pkg::CMD_WRITE: begin
          if (a_step >= ibe_pkg::WRITE_LAST_STEP) begin
            scl_nxt = 1'b0;
          end else begin
            case (ibe_pkg::mod3(a_step))
              2'd0: scl_nxt = 1'b0;
              2'd1: begin
                sda_nxt   = a_shift[7];
                shift_nxt = {a_shift[6:0], 1'b0};
              end
              default: scl_nxt = 1'b1;
            endcase
          end
        end
        ibe_pkg::CMD_READ: begin
          if (a_step == 5'd0) begin
            sda_nxt = 1'b1;
            scl_nxt = 1'b0;
          end else if (a_step[0]) begin
            scl_nxt = 1'b1;
          end else begin
            shift_nxt = {a_shift[6:0], item.sda_in};
            scl_nxt   = 1'b0;
            if (a_step >= ibe_pkg::READ_LAST_STEP) begin
              recv_nxt = {a_shift[6:0], item.sda_in};
            end
          end
        end
        default: ;
      endcase
    end
  end

  // State advances once per accepted request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= ibe_pkg::CMD_NONE;
      step_r   <= 5'd0;
      hold_r   <= 16'd0;
      shift_r  <= 8'd0;
      scl_r    <= 1'b1;
      sda_r    <= 1'b1;
      recv_r   <= 8'd0;
      nack_r   <= 1'b0;
    end else if (accept) begin
      active_r <= active_nxt;
      step_r   <= step_nxt;
      hold_r   <= hold_nxt;
      shift_r  <= shift_nxt;
      scl_r    <= scl_nxt;
      sda_r    <= sda_nxt;
      recv_r   <= recv_nxt;
      nack_r   <= nack_nxt;
    end
  end

  // The result shows the state after this request has been processed.
  always_comb begin
    result_nxt.scl_out   = scl_nxt;
    result_nxt.sda_out   = sda_nxt;
    result_nxt.busy_res  = (active_nxt != ibe_pkg::CMD_NONE);
    result_nxt.done_res  = done;
    result_nxt.read_data = recv_nxt;
    result_nxt.nack_seen = nack_nxt;
  end

`ifndef NO_ASSERTIONS
  // An idle engine holds no pending step or hold count.
  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (active_r == ibe_pkg::CMD_NONE) |-> (hold_r == 16'd0 && step_r == 5'd0))
    else $error("idle engine with pending hold or step");

  // A running command always has a nonzero hold count.
  a_busy_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (active_r != ibe_pkg::CMD_NONE) |-> (hold_r != 16'd0))
    else $error("running command with zero hold count");
`endif

endmodule

FILE: src/ibe_out_reg.sv
module ibe_out_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ibe_pkg::out_item_t result_nxt,
  output logic               accept,
  output logic               out_valid,
  input  logic               out_ready,
  output ibe_pkg::out_item_t out_data
);

  logic               out_valid_r;
  ibe_pkg::out_item_t out_data_r;

  // A new request may enter whenever the held result is gone or leaves now.
  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Payload register needs no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= result_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // Every accepted request yields a result in the next cycle.
  a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted request produced no result");

  // A completing tick never reports the engine as still busy.
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.done_res) |-> !out_data_r.busy_res)
    else $error("done and busy reported together");
`endif

endmodule
